/* rtl/core/pdtb_pkg.sv */
// Shared types and constants for the point distance table builder.
package pdtb_pkg;
    localparam int NODE_CAPACITY_DEF = 64;
    localparam int ID_W = 7;
    localparam int COORD_W = 16;
    localparam int DIST_W = 17;
    localparam int KEY_W = 32;
    localparam int SQ_W = 34;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic                      opcode;
        logic signed [COORD_W-1:0] x_first;
        logic signed [COORD_W-1:0] y_first;
        logic signed [COORD_W-1:0] x_second;
        logic signed [COORD_W-1:0] y_second;
        logic [ID_W-1:0]           query_node_a;
        logic [ID_W-1:0]           query_node_b;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [DIST_W-1:0] distance;
        logic [ID_W-1:0]   first_id;
        logic [ID_W-1:0]   second_id;
    } out_item_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SEARCH, S_ALLOC, S_SQ, S_ROOT,
        S_WR1, S_WR2, S_QRD, S_QWAIT, S_OUT
    } state_t;
endpackage

/* rtl/core/pdtb_if.sv */
// Valid/ready channel interface.
interface pdtb_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/pdtb_front.sv */
// Front: accepts items into a two-entry queue.
module pdtb_front (
    input  logic                 clk,
    input  logic                 rst_n,
    pdtb_if.sink                 in_ch,
    output pdtb_pkg::in_item_t   q_data,
    output logic                 q_valid,
    input  logic                 q_pop
);
    pdtb_pkg::in_item_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push = in_ch.valid && in_ch.ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_ch.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_pop && q_valid)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !in_ch.ready) else $error("ready while full");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 && !push) |=> !q_valid) else $error("phantom item");
endmodule

/* rtl/core/pdtb_back.sv */
// Back: point lookup, square root, distance store and result register.
module pdtb_back #(
    parameter int NODE_CAPACITY = pdtb_pkg::NODE_CAPACITY_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pdtb_pkg::in_item_t   q_data,
    input  logic                 q_valid,
    output logic                 q_pop,
    pdtb_if.source               out_ch
);
    localparam int IW = (NODE_CAPACITY > 1) ? $clog2(NODE_CAPACITY) : 1;
    localparam int CW = $clog2(NODE_CAPACITY + 1);
    localparam int AW = 2 * IW;
    localparam int DEPTH = 1 << AW;

    pdtb_pkg::state_t state_reg, state_next;

    logic [pdtb_pkg::KEY_W-1:0]  keys [NODE_CAPACITY];
    logic [pdtb_pkg::DIST_W-1:0] dmem [DEPTH];

    logic [CW-1:0] used_reg;
    logic [CW-1:0] idx_reg;
    logic [AW:0]   clr_reg;
    logic [pdtb_pkg::ID_W-1:0] id1_reg, id2_reg;
    logic [pdtb_pkg::KEY_W-1:0] k1_reg, k2_reg, key_rd_reg;
    logic          rd_ok_reg;
    logic [pdtb_pkg::SQ_W-1:0] num_reg, res_reg, bit_reg;
    logic [pdtb_pkg::DIST_W:0] dx_reg, dy_reg;
    logic [5:0]    step_reg;
    logic [pdtb_pkg::DIST_W-1:0] rd_reg;
    pdtb_pkg::out_item_t res_out_reg;
    logic          ovalid_reg;

    logic [CW:0] need;
    logic [pdtb_pkg::SQ_W-1:0] trial;
    logic        qbad;
    logic [pdtb_pkg::ID_W-1:0] qa, qb;

    assign qa = q_data.query_node_a;
    assign qb = q_data.query_node_b;
    assign qbad = (qa == '0) || (qb == '0) || ({25'd0, qa} > 32'(NODE_CAPACITY))
        || ({25'd0, qb} > 32'(NODE_CAPACITY));
    assign need = {{CW{1'b0}}, id1_reg == '0}
        + {{CW{1'b0}}, (id2_reg == '0) && (k2_reg != k1_reg)};
    assign trial = res_reg + bit_reg;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data = res_out_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pdtb_pkg::S_CLEAR:
                if (clr_reg == (AW+1)'(DEPTH - 1)) state_next = pdtb_pkg::S_IDLE;
            pdtb_pkg::S_IDLE:
                if (q_valid && !ovalid_reg)
                begin
                    if (q_data.opcode == pdtb_pkg::OP_EDGE)
                        state_next = pdtb_pkg::S_SEARCH;
                    else if (qbad)
                        state_next = pdtb_pkg::S_OUT;
                    else
                        state_next = pdtb_pkg::S_QRD;
                end
            pdtb_pkg::S_SEARCH:
                if (idx_reg > used_reg) state_next = pdtb_pkg::S_ALLOC;
            pdtb_pkg::S_ALLOC:
                if ({1'b0, used_reg} + need > (CW+1)'(NODE_CAPACITY))
                    state_next = pdtb_pkg::S_OUT;
                else
                    state_next = pdtb_pkg::S_SQ;
            pdtb_pkg::S_SQ:   state_next = pdtb_pkg::S_ROOT;
            pdtb_pkg::S_ROOT:
                if (step_reg == 6'd16) state_next = pdtb_pkg::S_WR1;
            pdtb_pkg::S_WR1:  state_next = pdtb_pkg::S_WR2;
            pdtb_pkg::S_WR2:  state_next = pdtb_pkg::S_OUT;
            pdtb_pkg::S_QRD:  state_next = pdtb_pkg::S_QWAIT;
            pdtb_pkg::S_QWAIT: state_next = pdtb_pkg::S_OUT;
            pdtb_pkg::S_OUT:  state_next = pdtb_pkg::S_IDLE;
            default:          state_next = pdtb_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop = (state_reg == pdtb_pkg::S_OUT);
    end

    // Key table read, one entry per cycle during search (registered).
    always_ff @(posedge clk)
    begin
        key_rd_reg <= keys[idx_reg[IW-1:0]];
        // keys stored one per cycle; a known key is rewritten with itself
        if (state_reg == pdtb_pkg::S_SQ)
            keys[IW'(id1_reg - 1'b1)] <= k1_reg;
        else if (state_reg == pdtb_pkg::S_WR1)
            keys[IW'(id2_reg - 1'b1)] <= k2_reg;
    end

    // Distance store: clear, mirrored writes, and a registered read alongside any write.
    always_ff @(posedge clk)
    begin
        if (state_reg == pdtb_pkg::S_CLEAR)
            dmem[clr_reg[AW-1:0]] <= '0;
        else if (state_reg == pdtb_pkg::S_WR1)
            dmem[{IW'(id1_reg - 1'b1), IW'(id2_reg - 1'b1)}] <= res_reg[16:0];
        else if (state_reg == pdtb_pkg::S_WR2)
            dmem[{IW'(id2_reg - 1'b1), IW'(id1_reg - 1'b1)}] <= res_reg[16:0];
        rd_reg <= dmem[{IW'(id1_reg - 1'b1), IW'(id2_reg - 1'b1)}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pdtb_pkg::S_CLEAR;
            used_reg <= '0;
            clr_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == pdtb_pkg::S_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (ovalid_reg && out_ch.ready) ovalid_reg <= 1'b0;
            if (state_reg == pdtb_pkg::S_OUT) ovalid_reg <= 1'b1;
            if (state_reg == pdtb_pkg::S_ALLOC && state_next == pdtb_pkg::S_SQ)
                used_reg <= used_reg + need[CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ok_reg <= (idx_reg < used_reg);
        case (state_reg)
            pdtb_pkg::S_IDLE:
            begin
                k1_reg <= {q_data.x_first, q_data.y_first};
                k2_reg <= {q_data.x_second, q_data.y_second};
                dx_reg <= {q_data.x_first[15], q_data.x_first[15], q_data.x_first}
                    - {q_data.x_second[15], q_data.x_second[15], q_data.x_second};
                dy_reg <= {q_data.y_first[15], q_data.y_first[15], q_data.y_first}
                    - {q_data.y_second[15], q_data.y_second[15], q_data.y_second};
                idx_reg <= '0;
                id1_reg <= qa;
                id2_reg <= qb;
                if (q_data.opcode == pdtb_pkg::OP_EDGE)
                begin
                    id1_reg <= '0;
                    id2_reg <= '0;
                end
                // keep a waiting result untouched
                if (!ovalid_reg)
                    res_out_reg <= {pdtb_pkg::ST_RANGE, 17'd0, qa, qb};
            end
            pdtb_pkg::S_SEARCH:
            begin
                idx_reg <= idx_reg + 1'b1;
                // key for idx_reg-1 is visible now
                if (idx_reg != '0 && rd_ok_reg)
                begin
                    if (key_rd_reg == k1_reg && id1_reg == '0)
                        id1_reg <= pdtb_pkg::ID_W'(idx_reg);
                    if (key_rd_reg == k2_reg && id2_reg == '0)
                        id2_reg <= pdtb_pkg::ID_W'(idx_reg);
                end
            end
            pdtb_pkg::S_ALLOC:
            begin
                res_out_reg <= {pdtb_pkg::ST_FULL, 17'd0, 7'd0, 7'd0};
                if (id1_reg == '0)
                begin
                    id1_reg <= pdtb_pkg::ID_W'(used_reg + 1'b1);
                    if (k2_reg == k1_reg)
                        id2_reg <= pdtb_pkg::ID_W'(used_reg + 1'b1);
                    else if (id2_reg == '0)
                        id2_reg <= pdtb_pkg::ID_W'(used_reg + 2'd2);
                end
                else if (id2_reg == '0)
                begin
                    id2_reg <= pdtb_pkg::ID_W'(used_reg + 1'b1);
                end
            end
            pdtb_pkg::S_SQ:
            begin
                num_reg <= 34'($signed(dx_reg) * $signed(dx_reg))
                    + 34'($signed(dy_reg) * $signed(dy_reg));
                res_reg <= '0;
                bit_reg <= 34'(1) << 32;
                step_reg <= '0;
            end
            pdtb_pkg::S_ROOT:
            begin
                step_reg <= step_reg + 1'b1;
                bit_reg <= bit_reg >> 2;
                if (num_reg >= trial)
                begin
                    num_reg <= num_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
            end
            pdtb_pkg::S_WR2:
                res_out_reg <= {pdtb_pkg::ST_OK, res_reg[16:0], id1_reg, id2_reg};
            pdtb_pkg::S_QWAIT:
                res_out_reg <= {pdtb_pkg::ST_OK, rd_reg, id1_reg, id2_reg};
            default: ;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(NODE_CAPACITY)) else $error("used count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pdtb_pkg::S_OUT) |=> ovalid_reg) else $error("result lost");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pdtb_pkg::S_WR1) |-> (id1_reg != '0 && id2_reg != '0))
        else $error("write with null id");
endmodule

/* rtl/core/point_distance_table_builder_top.sv */
// Top level of the point distance table builder.
// channel | dir | payload
// in_ch   | in  | opcode, coordinates, query ids
// out_ch  | out | status, distance, first_id, second_id
// Edge: start, key search over the used keys, alloc, square root, two writes, out;
// a full table ends after alloc. Query: read, wait, out; an id out of range goes
// straight to out.
// After reset, a clear pass over the whole distance store runs before any item is processed.
// A two-item queue decouples input; the result register holds under stall.
module point_distance_table_builder_top #(
    parameter int NODE_CAPACITY = pdtb_pkg::NODE_CAPACITY_DEF
) (
    input logic clk,
    input logic rst_n,
    pdtb_if.sink   in_ch,
    pdtb_if.source out_ch
);
    pdtb_pkg::in_item_t q_data;
    logic q_valid, q_pop;

    pdtb_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
    );

    pdtb_back #(.NODE_CAPACITY(NODE_CAPACITY)) u_back (
        .clk(clk), .rst_n(rst_n), .q_data(q_data), .q_valid(q_valid),
        .q_pop(q_pop), .out_ch(out_ch)
    );
endmodule
